// ===== rtl/scmm_pkg.sv =====
// ----------------------------------------------------------------------------
// scmm_pkg
// Shared types, codes and arithmetic helpers of the sparse column multiplier.
// ----------------------------------------------------------------------------
package scmm_pkg;

  typedef enum logic [1:0] {
    CMD_COL_START = 2'd0,
    CMD_ENTRY     = 2'd1,
    CMD_B_ENTRY   = 2'd2,
    CMD_END_COL   = 2'd3
  } cmd_t;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INNER_COUNT = 2'd1;

  localparam int CFG_W   = 7;
  localparam int ROW_W   = 6;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 48;
  localparam int SLOT_W  = 10;
  localparam int PTR_W   = 11;
  localparam int PROD_W  = 64;
  localparam int FRAC_W  = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef logic signed [ACC_W-1:0] acc_t;

  // signed add clamped to the 48-bit range
  function automatic acc_t sat_add(input acc_t a, input acc_t b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/scmm_ram.sv =====
// ----------------------------------------------------------------------------
// scmm_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module scmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scmm_mac.sv =====
// ----------------------------------------------------------------------------
// scmm_mac
// Q16.16 multiply into a product register, then saturating accumulate.
// ----------------------------------------------------------------------------
module scmm_mac
  import scmm_pkg::*;
(
  input  logic                    clk,
  input  logic                    load,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  input  acc_t                    acc_in,
  output acc_t                    sum
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= a * b;
    end
  end

  // dropping the low fraction bits rounds toward minus infinity
  assign sum = sat_add(acc_in, prod_r[FRAC_W+ACC_W-1:FRAC_W]);

endmodule

// ===== rtl/sparse_column_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// sparse_column_matrix_multiply
// Gustavson sparse product, A in compressed-column form, dense row accumulator.
// ----------------------------------------------------------------------------
// Loads of A (column start or entry) are written at once and never stall input.
// A B entry reads both column start pointers (S_LDS, S_LDE), then walks the A
// column: S_WRD, S_WMUL, S_WADD per in-range entry, S_WRD, S_WMUL per skipped
// one; a bad row goes to S_BAD. An end of column runs S_SCRD, S_SCCHK per row,
// then S_SCEND. Each memory has one read port; output stalls hold the emit states.
// Synchronous reset clears control, touched marks (accumulator reads as zero),
// column number, and sets both size registers to 64. Stores of A need loading.
module sparse_column_matrix_multiply
  import scmm_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_INNER  = 64,
  parameter int A_CAPACITY = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic [ROW_W-1:0]        in_row_index,
  input  logic signed [VAL_W-1:0] in_entry_value,
  input  logic [PTR_W-1:0]        in_start_pointer,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ROW_W-1:0]        out_column,
  output logic [ROW_W-1:0]        out_row,
  output logic signed [ACC_W-1:0] out_value,
  output logic                    out_last,
  output logic                    out_empty_column,
  output logic                    out_bad_row,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_INNER + 1);
  localparam int AW = $clog2(A_CAPACITY);
  localparam int ZW = (AW + 1 > PTR_W) ? AW + 1 : PTR_W;
  localparam int EW = ROW_W + VAL_W;
  localparam logic [ZW-1:0]    CAP_Z    = ZW'(A_CAPACITY);
  localparam logic [CFG_W-1:0] ROWS_L   = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] INNER_L  = CFG_W'(MAX_INNER);

  typedef enum logic [3:0] {
    S_IDLE, S_BAD, S_LDS, S_LDE, S_WRD, S_WMUL, S_WADD, S_SCRD, S_SCCHK, S_SCEND
  } state_t;

  state_t state_r;
  logic [CFG_W-1:0] row_count_r, inner_count_r;
  logic [ROW_W-1:0] column_r;
  logic [MAX_ROWS-1:0] touched_r;
  logic [ROW_W-1:0] b_row_r;
  logic signed [VAL_W-1:0] b_val_r;
  logic [ZW-1:0] s_r, e_r, z_r;
  logic [ROW_W-1:0] cur_row_r;
  logic [CFG_W-1:0] q_r;
  logic pend_v_r;
  logic [ROW_W-1:0] pend_row_r;
  acc_t pend_val_r;

  logic in_acc, out_free, out_load;
  logic [CFG_W-1:0] lim_rows, lim_inner;
  logic [CFG_W-1:0] b_row_ext;
  logic [ZW-1:0] slot_ext, cs_cap, z_inc;

  logic cs_we;
  logic [CW-1:0] cs_waddr, cs_raddr;
  logic [PTR_W-1:0] cs_rdata;
  logic ent_we;
  logic [EW-1:0] ent_rdata;
  logic [ROW_W-1:0] ent_row;
  logic signed [VAL_W-1:0] ent_val;
  logic acc_we;
  logic [RW-1:0] acc_raddr;
  acc_t acc_rdata, acc_old, mac_sum;
  logic scan_hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign lim_rows  = (row_count_r > ROWS_L) ? ROWS_L : row_count_r;
  assign lim_inner = (inner_count_r > INNER_L) ? INNER_L : inner_count_r;
  assign b_row_ext = CFG_W'(in_row_index);
  assign slot_ext  = ZW'(in_slot);
  assign cs_cap    = (ZW'(cs_rdata) > CAP_Z) ? CAP_Z : ZW'(cs_rdata);
  assign z_inc     = z_r + ZW'(1);

  assign ent_row   = ent_rdata[EW-1:VAL_W];
  assign ent_val   = ent_rdata[VAL_W-1:0];
  assign acc_old   = touched_r[cur_row_r[RW-1:0]] ? acc_rdata : '0;
  assign scan_hit  = touched_r[q_r[RW-1:0]] && (acc_rdata != '0);

  // a new result is loaded into the output register this cycle
  assign out_load  = ((state_r == S_BAD) || (state_r == S_SCEND) ||
                      ((state_r == S_SCCHK) && scan_hit && pend_v_r)) && out_free;

  always_comb begin
    cs_we    = in_acc && (cmd_t'(in_command) == CMD_COL_START) &&
               (ZW'(in_slot) <= ZW'(MAX_INNER));
    cs_waddr = in_slot[CW-1:0];
    cs_raddr = (state_r == S_LDS) ? CW'(CFG_W'(b_row_r) + CFG_W'(1)) : CW'(in_row_index);
    ent_we   = in_acc && (cmd_t'(in_command) == CMD_ENTRY) && (slot_ext < CAP_Z);
    acc_we   = (state_r == S_WADD);
    acc_raddr = (state_r == S_WMUL) ? ent_row[RW-1:0] : q_r[RW-1:0];
  end

  scmm_ram #(.WIDTH(PTR_W), .DEPTH(MAX_INNER + 1)) u_starts (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(in_start_pointer),
    .raddr(cs_raddr), .rdata(cs_rdata)
  );

  scmm_ram #(.WIDTH(EW), .DEPTH(A_CAPACITY)) u_entries (
    .clk(clk), .we(ent_we), .waddr(slot_ext[AW-1:0]),
    .wdata({in_row_index, in_entry_value}),
    .raddr(z_r[AW-1:0]), .rdata(ent_rdata)
  );

  scmm_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ROWS)) u_acc (
    .clk(clk), .we(acc_we), .waddr(cur_row_r[RW-1:0]), .wdata(mac_sum),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  scmm_mac u_mac (
    .clk(clk), .load(state_r == S_WMUL), .a(ent_val), .b(b_val_r),
    .acc_in(acc_old), .sum(mac_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      row_count_r   <= CFG_RESET;
      inner_count_r <= CFG_RESET;
      column_r      <= '0;
      touched_r     <= '0;
      pend_v_r      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROW_COUNT:   row_count_r   <= cfg_data;
          CFG_INNER_COUNT: inner_count_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          b_row_r <= in_row_index;
          b_val_r <= in_entry_value;
          q_r     <= '0;
          if (in_acc) begin
            unique case (cmd_t'(in_command))
              CMD_B_ENTRY: state_r <= (b_row_ext < lim_inner) ? S_LDS : S_BAD;
              CMD_END_COL: state_r <= S_SCRD;
              default:     state_r <= S_IDLE;
            endcase
          end
        end
        S_BAD: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_column       <= column_r;
            out_row          <= '0;
            out_value        <= '0;
            out_last         <= 1'b1;
            out_empty_column <= 1'b0;
            out_bad_row      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        S_LDS: begin
          s_r     <= cs_cap;
          state_r <= S_LDE;
        end
        S_LDE: begin
          e_r     <= cs_cap;
          z_r     <= s_r;
          state_r <= (s_r < cs_cap) ? S_WRD : S_IDLE;
        end
        S_WRD: begin
          state_r <= S_WMUL;
        end
        S_WMUL: begin
          cur_row_r <= ent_row;
          if (CFG_W'(ent_row) < lim_rows) begin
            state_r <= S_WADD;
          end else begin
            z_r     <= z_inc;
            state_r <= (z_inc < e_r) ? S_WRD : S_IDLE;
          end
        end
        S_WADD: begin
          touched_r[cur_row_r[RW-1:0]] <= 1'b1;
          z_r     <= z_inc;
          state_r <= (z_inc < e_r) ? S_WRD : S_IDLE;
        end
        S_SCRD: begin
          state_r <= (q_r < lim_rows) ? S_SCCHK : S_SCEND;
        end
        S_SCCHK: begin
          // hold the previous hit until the next one proves it is not last
          if (!(scan_hit && pend_v_r && !out_free)) begin
            if (scan_hit) begin
              if (pend_v_r) begin
                out_valid        <= 1'b1;
                out_column       <= column_r;
                out_row          <= pend_row_r;
                out_value        <= pend_val_r;
                out_last         <= 1'b0;
                out_empty_column <= 1'b0;
                out_bad_row      <= 1'b0;
              end
              pend_v_r   <= 1'b1;
              pend_row_r <= q_r[ROW_W-1:0];
              pend_val_r <= acc_rdata;
            end
            q_r     <= q_r + CFG_W'(1);
            state_r <= S_SCRD;
          end
        end
        S_SCEND: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_column       <= column_r;
            out_row          <= pend_v_r ? pend_row_r : '0;
            out_value        <= pend_v_r ? pend_val_r : '0;
            out_last         <= 1'b1;
            out_empty_column <= !pend_v_r;
            out_bad_row      <= 1'b0;
            pend_v_r         <= 1'b0;
            touched_r        <= '0;
            column_r         <= column_r + ROW_W'(1);
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/scmm_checker.sv =====
// ----------------------------------------------------------------------------
// scmm_checker
// Port-level checks on the sparse column multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module scmm_checker
  import scmm_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_command,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [ROW_W-1:0]        out_row,
  input logic signed [ACC_W-1:0] out_value,
  input logic                    out_last,
  input logic                    out_empty_column,
  input logic                    out_bad_row
);

  // no result may be shown right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // empty marker closes its item and carries zeros
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_column |->
      out_last && !out_bad_row && out_row == '0 && out_value == '0)
    else $error("malformed empty marker");

  a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_row |-> out_last && out_row == '0 && out_value == '0)
    else $error("malformed bad row result");

  // B entries and column ends are multi-cycle work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_command == CMD_B_ENTRY || in_command == CMD_END_COL) |=> in_stall)
    else $error("input taken during multi-cycle work");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_row))
    else $error("stalled result changed");

endmodule

bind sparse_column_matrix_multiply scmm_checker u_scmm_checker (.*);

// ===== tb/sparse_column_matrix_multiply_test.sv =====
// ----------------------------------------------------------------------------
// sparse_column_matrix_multiply_test
// Loads sparse A matrices, streams B columns through the block under several
// size settings and checks every emitted sum against a local product model.
// ----------------------------------------------------------------------------
module sparse_column_matrix_multiply_test;
  import scmm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS      = 64;
  localparam int NINNER     = 64;
  localparam int CAPACITY   = 1024;
  localparam int CYCLE_CAP  = 3_000_000;
  localparam int DRAIN_WAIT = 3200;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    cmd_t              command;
    logic [9:0]        slot;
    logic [5:0]        row;
    logic signed [31:0] value;
    logic [10:0]       ptr;
  } mat_item_t;

  typedef struct {
    logic [5:0]         column;
    logic [5:0]         row;
    logic signed [47:0] value;
    bit                 last;
    bit                 empty;
    bit                 bad;
  } col_result_t;

  typedef struct {
    mat_item_t   item;
    bit          fixed;
    col_result_t result;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_command;
  logic [SLOT_W-1:0] in_slot;
  logic [ROW_W-1:0] in_row_index;
  logic signed [VAL_W-1:0] in_entry_value;
  logic [PTR_W-1:0] in_start_pointer;
  logic out_valid, out_stall;
  logic [ROW_W-1:0] out_column, out_row;
  logic signed [ACC_W-1:0] out_value;
  logic out_last, out_empty_column, out_bad_row;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  sparse_column_matrix_multiply u_top (.*);

  // local copy of the block state
  logic [6:0]         row_limit_reg, inner_limit_reg;
  logic [10:0]        col_start[NINNER+1];
  bit                 col_start_set[NINNER+1];
  logic [5:0]         a_row[CAPACITY];
  logic signed [31:0] a_value[CAPACITY];
  bit                 a_set[CAPACITY];
  logic signed [47:0] row_sum[NROWS];
  bit                 row_hit[NROWS];
  logic [5:0]         column_no;

  col_result_t   pending_sums[$];
  directed_row_t directed[$];
  int  failures;
  int  cycles;
  bit  hold_now;
  bit  quiet;
  int  loaded_top;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0001_0000;
      3: return -32'sh1;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit walk_known(int r);
    int s, e;
    if (!col_start_set[r] || !col_start_set[r+1]) return 0;
    s = (col_start[r] > CAPACITY) ? CAPACITY : col_start[r];
    e = (col_start[r+1] > CAPACITY) ? CAPACITY : col_start[r+1];
    for (int z = s; z < e; z++) if (!a_set[z]) return 0;
    return 1;
  endfunction

  task automatic clear_model();
    row_limit_reg = 7'd64;
    inner_limit_reg = 7'd64;
    column_no = 0;
    for (int i = 0; i <= NINNER; i++) col_start_set[i] = 0;
    for (int i = 0; i < CAPACITY; i++) a_set[i] = 0;
    for (int i = 0; i < NROWS; i++) begin
      row_sum[i] = 0;
      row_hit[i] = 0;
    end
  endtask

  // column product step: updates state, returns the sums it emits
  task automatic product_step(input mat_item_t it, ref col_result_t sums[$]);
    int lim_rows, lim_inner, s, e, r, n;
    logic signed [63:0] pa, pb, p, t;
    col_result_t res;
    lim_rows = (row_limit_reg < NROWS) ? row_limit_reg : NROWS;
    lim_inner = (inner_limit_reg < NINNER) ? inner_limit_reg : NINNER;
    res = '{column: column_no, row: 0, value: 0, last: 1, empty: 0, bad: 0};
    case (it.command)
      CMD_COL_START: begin
        if (it.slot <= NINNER) begin
          col_start[it.slot] = it.ptr;
          col_start_set[it.slot] = 1;
        end
      end
      CMD_ENTRY: begin
        a_row[it.slot] = it.row;
        a_value[it.slot] = it.value;
        a_set[it.slot] = 1;
      end
      CMD_B_ENTRY: begin
        if (it.row >= lim_inner) begin
          res.bad = 1;
          sums.insert(sums.size(), res);
        end else begin
          s = (col_start[it.row] > CAPACITY) ? CAPACITY : col_start[it.row];
          e = (col_start[it.row+1] > CAPACITY) ? CAPACITY : col_start[it.row+1];
          for (int z = s; z < e; z++) begin
            r = a_row[z];
            if (r < lim_rows) begin
              pa = a_value[z];
              pb = it.value;
              p = (pa * pb) >>> 16;
              t = p + row_sum[r];
              if (t > 64'sh7FFF_FFFF_FFFF) t = 64'sh7FFF_FFFF_FFFF;
              else if (t < -64'sh8000_0000_0000) t = -64'sh8000_0000_0000;
              row_sum[r] = t[47:0];
              row_hit[r] = 1;
            end
          end
        end
      end
      CMD_END_COL: begin
        n = 0;
        for (int i = 0; i < lim_rows; i++) begin
          if (row_hit[i] && row_sum[i] != 0) begin
            res.row = i;
            res.value = row_sum[i];
            res.last = 0;
            sums.insert(sums.size(), res);
            n++;
          end
        end
        if (n == 0) begin
          res.empty = 1;
          sums.insert(sums.size(), res);
        end else begin
          sums[sums.size()-1].last = 1;
        end
        for (int i = 0; i < NROWS; i++) begin
          row_sum[i] = 0;
          row_hit[i] = 0;
        end
        column_no = column_no + 1;
      end
    endcase
  endtask

  task automatic send(input mat_item_t it, input bit fixed = 0,
                      input col_result_t fixed_res = '{default: 0});
    int gap;
    col_result_t sums[$];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= it.command;
    in_slot <= it.slot;
    in_row_index <= it.row;
    in_entry_value <= it.value;
    in_start_pointer <= it.ptr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    product_step(it, sums);
    if (fixed) pending_sums.insert(pending_sums.size(), fixed_res);
    else foreach (sums[i]) pending_sums.insert(pending_sums.size(), sums[i]);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [6:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == CFG_ROW_COUNT) row_limit_reg = data;
    else if (idx == CFG_INNER_COUNT) inner_limit_reg = data;
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic mat_item_t mk(cmd_t c, int slot, int row, logic signed [31:0] v,
                                   int ptr);
    mat_item_t it;
    it.command = c;
    it.slot = slot;
    it.row = row;
    it.value = v;
    it.ptr = ptr;
    return it;
  endfunction

  task automatic add_row(input mat_item_t it, input bit fixed = 0,
                         input col_result_t res = '{default: 0});
    directed_row_t d;
    d.item = it;
    d.fixed = fixed;
    d.result = res;
    directed.insert(directed.size(), d);
  endtask

  task automatic load_matrix();
    int ptr, n;
    ptr = 0;
    for (int c = 0; c <= NINNER; c++) begin
      send(mk(CMD_COL_START, c, 0, 0, ptr));
      if (c < NINNER) begin
        n = $urandom_range(0, 2);
        ptr += n;
      end
    end
    for (int z = 0; z < ptr; z++) begin
      n = ($urandom_range(0, 9) < 8 && row_limit_reg > 0 && row_limit_reg <= NROWS) ?
          $urandom_range(0, row_limit_reg - 1) : $urandom_range(0, 63);
      send(mk(CMD_ENTRY, z, n, pick_value(), 0));
    end
    loaded_top = ptr;
  endtask

  task automatic random_stream(input int count);
    int sel, r, tries, lim_inner;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      lim_inner = (inner_limit_reg < NINNER) ? inner_limit_reg : NINNER;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        tries = 0;
        do begin
          r = ($urandom_range(0, 9) < 8 && lim_inner > 0) ?
              $urandom_range(0, lim_inner - 1) : $urandom_range(0, 63);
          tries++;
        end while (r < lim_inner && !walk_known(r) && tries < 10);
        if (r < lim_inner && !walk_known(r))
          send(mk(CMD_END_COL, $urandom, $urandom, $urandom, $urandom));
        else
          send(mk(CMD_B_ENTRY, $urandom, r, pick_value(), $urandom));
      end else if (sel < 75) begin
        send(mk(CMD_END_COL, $urandom, $urandom, $urandom, $urandom));
      end else if (sel < 85) begin
        send(mk(CMD_ENTRY, $urandom_range(0, 1023), $urandom, pick_value(), $urandom));
      end else if (sel < 93) begin
        send(mk(CMD_COL_START, $urandom_range(0, NINNER), $urandom, $urandom,
                ($urandom_range(0, 4) < 3) ? $urandom_range(0, loaded_top)
                                            : $urandom_range(0, 2047)));
      end else begin
        send(mk(CMD_COL_START, $urandom_range(NINNER + 1, 1023), $urandom, $urandom,
                $urandom));
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    col_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $error("result transfer with nothing expected");
        failures++;
      end else begin
        want = pending_sums.pop_front();
        if (out_column !== want.column) begin
          $error("column: expected %0d, got %0d", want.column, out_column);
          failures++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          failures++;
        end
        if (out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_value);
          failures++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          failures++;
        end
        if (out_empty_column !== want.empty) begin
          $error("empty_column: expected %0d, got %0d", want.empty, out_empty_column);
          failures++;
        end
        if (out_bad_row !== want.bad) begin
          $error("bad_row: expected %0d, got %0d", want.bad, out_bad_row);
          failures++;
        end
      end
    end
  end

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 0;
        out_stall <= 1;
        repeat (500) @(posedge clk);
        out_stall <= 0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1;
          repeat (n) @(posedge clk);
          out_stall <= 0;
        end
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    int row_cfg[5], inner_cfg[5];
    in_valid = 0;
    in_command = 0;
    in_slot = 0;
    in_row_index = 0;
    in_entry_value = 0;
    in_start_pointer = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    failures = 0;
    cycles = 0;
    hold_now = 0;
    quiet = 0;
    loaded_top = 0;
    clear_model();
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_reg(CFG_INNER_COUNT, 7'd8);

    // directed part: empty column, bad rows, ignored loads, capped pointers,
    // saturation in both directions
    add_row(mk(CMD_END_COL, 0, 0, 0, 0), 1,
            '{column: 0, row: 0, value: 0, last: 1, empty: 1, bad: 0});
    add_row(mk(CMD_B_ENTRY, 0, 63, 32'sh7FFF_FFFF, 0), 1,
            '{column: 1, row: 0, value: 0, last: 1, empty: 0, bad: 1});
    add_row(mk(CMD_B_ENTRY, 0, 8, 32'sh8000_0000, 0), 1,
            '{column: 1, row: 0, value: 0, last: 1, empty: 0, bad: 1});
    add_row(mk(CMD_COL_START, 1023, 0, 0, 2047));
    add_row(mk(CMD_COL_START, 0, 0, 0, 0));
    add_row(mk(CMD_COL_START, 1, 0, 0, 3));
    add_row(mk(CMD_COL_START, 2, 0, 0, 5));
    add_row(mk(CMD_COL_START, 3, 0, 0, 5));
    add_row(mk(CMD_COL_START, 4, 0, 0, 2047));
    add_row(mk(CMD_COL_START, 5, 0, 0, 1024));
    add_row(mk(CMD_COL_START, 6, 0, 0, 7));
    add_row(mk(CMD_ENTRY, 0, 0, 32'sh7FFF_FFFF, 0));
    add_row(mk(CMD_ENTRY, 1, 63, 32'sh8000_0000, 0));
    add_row(mk(CMD_ENTRY, 2, 5, 32'sh0001_0000, 0));
    add_row(mk(CMD_ENTRY, 3, 0, 32'sh1, 0));
    add_row(mk(CMD_ENTRY, 4, 2, -32'sh1, 0));
    add_row(mk(CMD_B_ENTRY, 0, 0, 32'sh8000_0000, 0));
    add_row(mk(CMD_B_ENTRY, 0, 0, 32'sh8000_0000, 0));
    add_row(mk(CMD_B_ENTRY, 0, 0, 32'sh8000_0000, 0));
    add_row(mk(CMD_B_ENTRY, 0, 1, 32'sh7FFF_FFFF, 0));
    add_row(mk(CMD_B_ENTRY, 0, 2, 32'sh1234_5678, 0));
    add_row(mk(CMD_B_ENTRY, 0, 4, 32'sh0001_0000, 0));
    add_row(mk(CMD_B_ENTRY, 0, 5, 32'sh0001_0000, 0));
    add_row(mk(CMD_END_COL, 0, 0, 0, 0));
    foreach (directed[i]) send(directed[i].item, directed[i].fixed, directed[i].result);
    wait_idle();

    // size settings, extremes included; out-of-range values are legal writes
    row_cfg   = '{64, 1, 0, 127, $urandom_range(2, 63)};
    inner_cfg = '{64, 1, 0, 127, $urandom_range(2, 63)};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_ROW_COUNT, row_cfg[ph]);
      write_reg(CFG_INNER_COUNT, inner_cfg[ph]);
      if (ph == 2) write_reg(CFG_UNUSED, 7'h7F);
      if (ph == 0) begin
        load_matrix();
        hold_now = 1;
      end
      random_stream(45);
      wait_idle();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
